// ----- sv/dtr_pkg.sv -----
// ----------------------------------------------------------------------------
// dtr_pkg: shared types and constants for the divider timer
// codes, register addresses and item types used by the core and the top level
// ----------------------------------------------------------------------------
package dtr_pkg;

	// item opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// register addresses
	localparam logic [15:0] ADDR_DIV  = 16'hFF04;
	localparam logic [15:0] ADDR_TIMA = 16'hFF05;
	localparam logic [15:0] ADDR_TMA  = 16'hFF06;
	localparam logic [15:0] ADDR_TAC  = 16'hFF07;

	// reload phase codes
	localparam logic [1:0] PHASE_IDLE     = 2'd0;
	localparam logic [1:0] PHASE_OVERFLOW = 2'd1;
	localparam logic [1:0] PHASE_RELOAD   = 2'd2;

	localparam logic [15:0] DIV_RESET    = 16'hABCC;
	localparam logic [15:0] DIV_STEP     = 16'h0004;
	localparam logic [2:0]  TAC_MASK     = 3'h7;
	localparam logic [7:0]  TAC_READ_SET = 8'hF8;
	localparam logic [7:0]  BYTE_ONES    = 8'hFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] reg_address;
		logic [7:0]  write_data;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} result_t;

	// divider bit picked by the clock select field: 9, 3, 5 or 7
	function automatic logic tap_bit(input logic [15:0] div, input logic [1:0] sel);
		logic b;
		case (sel)
			2'd0: b = div[9];
			2'd1: b = div[3];
			2'd2: b = div[5];
			default: b = div[7];
		endcase
		return b;
	endfunction

endpackage

// ----- sv/dtr_core.sv -----
// ----------------------------------------------------------------------------
// dtr_core: timer state and single-pass update
// holds DIV/TIMA/TMA/TAC state and applies one item per step
// ----------------------------------------------------------------------------
module dtr_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  dtr_pkg::item_t  item,
	output dtr_pkg::result_t result
);

	logic [15:0] div_q;
	logic [7:0]  cnt_q;
	logic [7:0]  mod_q;
	logic [2:0]  ctl_q;
	logic        last_q;
	logic [1:0]  phase_q;

	logic [15:0] div_n;
	logic [7:0]  cnt_n;
	logic [7:0]  mod_n;
	logic [2:0]  ctl_n;
	logic        last_n;
	logic [1:0]  phase_n;
	logic        sample;
	logic        now_bit;
	dtr_pkg::result_t res;

	always_comb begin
		div_n   = div_q;
		cnt_n   = cnt_q;
		mod_n   = mod_q;
		ctl_n   = ctl_q;
		last_n  = last_q;
		phase_n = phase_q;
		sample  = 1'b0;
		res     = '0;
		case (item.opcode)
			dtr_pkg::OP_TICK: begin
				if (phase_q == dtr_pkg::PHASE_OVERFLOW) begin
					cnt_n         = mod_q;
					res.timer_irq = 1'b1;
					phase_n       = dtr_pkg::PHASE_RELOAD;
				end else if (phase_q == dtr_pkg::PHASE_RELOAD) begin
					phase_n = dtr_pkg::PHASE_IDLE;
				end
				div_n  = div_q + dtr_pkg::DIV_STEP;
				sample = 1'b1;
			end
			dtr_pkg::OP_READ: begin
				case (item.reg_address)
					dtr_pkg::ADDR_DIV:  res.read_data = div_q[15:8];
					dtr_pkg::ADDR_TIMA: res.read_data = cnt_q;
					dtr_pkg::ADDR_TMA:  res.read_data = mod_q;
					dtr_pkg::ADDR_TAC:  res.read_data = {5'b0, ctl_q} | dtr_pkg::TAC_READ_SET;
					default:            res.read_data = dtr_pkg::BYTE_ONES;
				endcase
			end
			dtr_pkg::OP_WRITE: begin
				case (item.reg_address)
					dtr_pkg::ADDR_DIV: begin
						div_n  = '0;
						sample = 1'b1;
					end
					dtr_pkg::ADDR_TIMA: begin
						// write is dropped while the reload is in progress
						if (phase_q != dtr_pkg::PHASE_RELOAD) begin
							cnt_n   = item.write_data;
							phase_n = dtr_pkg::PHASE_IDLE;
						end
					end
					dtr_pkg::ADDR_TMA: begin
						mod_n = item.write_data;
						if (phase_q == dtr_pkg::PHASE_RELOAD) begin
							cnt_n = item.write_data;
						end
					end
					dtr_pkg::ADDR_TAC: begin
						ctl_n  = item.write_data[2:0] & dtr_pkg::TAC_MASK;
						sample = 1'b1;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		// falling edge of the gated divider tap bumps the counter
		now_bit = dtr_pkg::tap_bit(div_n, ctl_n[1:0]) & ctl_n[2];
		if (sample) begin
			if (last_q && !now_bit) begin
				if (cnt_n == dtr_pkg::BYTE_ONES) begin
					cnt_n   = '0;
					phase_n = dtr_pkg::PHASE_OVERFLOW;
				end else begin
					cnt_n = cnt_n + 8'd1;
				end
			end
			last_n = now_bit;
		end
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= dtr_pkg::DIV_RESET;
			cnt_q   <= '0;
			mod_q   <= '0;
			ctl_q   <= '0;
			last_q  <= 1'b0;
			phase_q <= dtr_pkg::PHASE_IDLE;
		end else if (step) begin
			div_q   <= div_n;
			cnt_q   <= cnt_n;
			mod_q   <= mod_n;
			ctl_q   <= ctl_n;
			last_q  <= last_n;
			phase_q <= phase_n;
		end
	end

endmodule

// ----- sv/divider_timer_with_reload.sv -----
// ----------------------------------------------------------------------------
// divider_timer_with_reload: DIV/TIMA/TMA/TAC timer with delayed reload
// takes ticks, bus reads and bus writes, returns one result per item
// ----------------------------------------------------------------------------
//
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------
// in       | in_valid / in_ready   | opcode, reg_address, write_data
// out      | out_valid / out_ready | read_data, timer_irq
//
// one item per cycle sustained while the output is not stalled; each item
// passes the input register, then the result register, before its result
// is offered for the output transfer
// the rate is set by the single-pass update in the core: each item reads the
// state left by the item before it and writes it back in the same cycle
// arst_n clears the pipeline valids and puts the timer state to its reset
// values (divider 0xABCC, everything else zero)
// a stalled output holds the result and the item in the input register;
// input is still taken while the input register is empty or draining
//
module divider_timer_with_reload (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [15:0] reg_address,
	input  logic [7:0]  write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        timer_irq
);

	// input register
	logic           valid_s1;
	dtr_pkg::item_t item_s1;

	// result register
	logic             valid_s2;
	dtr_pkg::result_t result_s2;

	dtr_pkg::result_t core_result;
	logic             advance;

	// item in stage 1 moves on when the result register is free or emptying
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload only captured on a transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{opcode: opcode, reg_address: reg_address, write_data: write_data};
		end
	end

	// state update happens on the same edge the result is registered
	dtr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= core_result;
		end
	end

	assign out_valid = valid_s2;
	assign read_data = result_s2.read_data;
	assign timer_irq = result_s2.timer_irq;

	// an interrupt result only comes from a tick, which reads nothing
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.timer_irq) |-> (result_s2.read_data == 8'h00))
		else $error("timer interrupt result carries read data");

	// a held item in stage 1 stays there until it advances
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("stage 1 item lost while stalled");

	// a new transfer into a full stage 1 only happens when it drains
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && valid_s1) |-> advance)
		else $error("input transfer overwrote a pending item");

endmodule
